// ===== design/tlqe_pkg.sv =====
`timescale 1ns / 1ps

package tlqe_pkg;

    localparam int COORD_BITS = 20;
    localparam int INDEX_BITS = 16;
    localparam int SW_BITS    = 16;
    localparam int COLOR_BITS = 32;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 32;

    // magnitude of a coordinate difference
    localparam int DIFF_BITS = COORD_BITS;
    localparam int SQ_BITS   = 2 * DIFF_BITS + 1;
    localparam int RAD_BITS  = SQ_BITS + 17;
    localparam int ROOT_BITS = RAD_BITS / 2;
    localparam int REM_BITS  = ROOT_BITS + 2;
    localparam int PROD_BITS = DIFF_BITS + SW_BITS;
    localparam int DVD_BITS  = PROD_BITS + 5;
    localparam int DVS_BITS  = ROOT_BITS + 1;
    localparam int Q_BITS    = 13;
    localparam int CNT_BITS  = 5;
    localparam int SLOT_BITS = 4;

    localparam logic [SLOT_BITS-1:0] SLOT_LAST_VERT = 4'd3;
    localparam logic [SLOT_BITS-1:0] SLOT_LAST_IDX  = 4'd9;
    localparam logic [SLOT_BITS-1:0] SLOT_CMD       = 4'd10;

    localparam logic [CFG_IDX_BITS-1:0] CFG_STROKE_WIDTH = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STROKE_COLOR = 1'd1;

    localparam logic [SW_BITS-1:0]    SW_RESET    = 16'd256;
    localparam logic [COLOR_BITS-1:0] COLOR_RESET = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_INDEX  = 2'd1,
        KIND_CMD    = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_TAKE   = 3'd1,
        OP_MULX   = 3'd2,
        OP_MULY   = 3'd3,
        OP_SQRT   = 3'd4,
        OP_DIVI_X = 3'd5,
        OP_DIVI_Y = 3'd6,
        OP_DIV    = 3'd7
    } t_dp_op;

    typedef struct packed {
        t_dp_op                op;
        logic                  emit;
        logic [SLOT_BITS-1:0]  slot;
        logic                  commit;
    } t_dp_cmd;

    typedef struct packed {
        logic seg;
        logic fin;
        logic out_free;
    } t_dp_stat;

    function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [COORD_BITS:0] v);
        logic [COORD_BITS-1:0] res;
        if (v[COORD_BITS] != v[COORD_BITS-1]) begin
            res = {v[COORD_BITS], {(COORD_BITS-1){~v[COORD_BITS]}}};
        end else begin
            res = v[COORD_BITS-1:0];
        end
        return res;
    endfunction

    // vertex offset inside the quad for the two triangles
    function automatic logic [1:0] tri_ofs(input logic [SLOT_BITS-1:0] slot);
        logic [1:0] res;
        case (slot)
            4'd4:    res = 2'd0;
            4'd5:    res = 2'd1;
            4'd6:    res = 2'd2;
            4'd7:    res = 2'd1;
            4'd8:    res = 2'd2;
            4'd9:    res = 2'd3;
            default: res = 2'd0;
        endcase
        return res;
    endfunction

endpackage

// ===== design/tlqe_ifs.sv =====
`timescale 1ns / 1ps

interface tlqe_point_if import tlqe_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         first_point;
    logic                         final_point;

    modport source(output valid, point_x, point_y, first_point, final_point, input ready);
    modport sink(input valid, point_x, point_y, first_point, final_point, output ready);
endinterface

interface tlqe_result_if import tlqe_pkg::*; ();
    logic                         valid;
    logic                         ready;
    t_kind                        kind;
    logic signed [COORD_BITS-1:0] vert_x;
    logic signed [COORD_BITS-1:0] vert_y;
    logic [COLOR_BITS-1:0]        vert_color;
    logic [INDEX_BITS-1:0]        index_value;
    logic                         last_result;

    modport source(output valid, kind, vert_x, vert_y, vert_color, index_value, last_result,
                   input ready);
    modport sink(input valid, kind, vert_x, vert_y, vert_color, index_value, last_result,
                 output ready);
endinterface

interface tlqe_cfg_if import tlqe_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== design/tlqe_ctrl.sv =====
`timescale 1ns / 1ps

module tlqe_ctrl import tlqe_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_dp_stat i_stat,
    output logic     o_ready,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_BRANCH = 10'b00_0000_0010,
        S_MULY   = 10'b00_0000_0100,
        S_SQRT   = 10'b00_0000_1000,
        S_DIVXI  = 10'b00_0001_0000,
        S_DIVX   = 10'b00_0010_0000,
        S_DIVYI  = 10'b00_0100_0000,
        S_DIVY   = 10'b00_1000_0000,
        S_EMIT   = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic [SLOT_BITS-1:0] r_slot, n_slot;
    logic                 last_slot;

    assign last_slot = (r_slot == SLOT_CMD) || ((r_slot == SLOT_LAST_IDX) && !i_stat.fin);
    assign o_ready   = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_slot       = r_slot;
        o_cmd.op     = OP_NONE;
        o_cmd.emit   = 1'b0;
        o_cmd.slot   = r_slot;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_TAKE;
                    n_state  = S_BRANCH;
                end
            end
            S_BRANCH: begin
                o_cmd.op = OP_MULX;
                if (i_stat.seg) begin
                    n_state = S_MULY;
                end else if (i_stat.fin) begin
                    n_slot  = SLOT_CMD;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MULY: begin
                o_cmd.op = OP_MULY;
                n_cnt    = '0;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(ROOT_BITS - 1)) begin
                    n_state = S_DIVXI;
                end
            end
            S_DIVXI: begin
                o_cmd.op = OP_DIVI_X;
                n_cnt    = '0;
                n_state  = S_DIVX;
            end
            S_DIVX: begin
                o_cmd.op = OP_DIV;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(Q_BITS - 1)) begin
                    n_state = S_DIVYI;
                end
            end
            S_DIVYI: begin
                o_cmd.op = OP_DIVI_Y;
                n_cnt    = '0;
                n_state  = S_DIVY;
            end
            S_DIVY: begin
                o_cmd.op = OP_DIV;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(Q_BITS - 1)) begin
                    n_slot  = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (last_slot) begin
                        n_state = S_DONE;
                    end else if (r_slot == SLOT_LAST_IDX) begin
                        n_slot = SLOT_CMD;
                    end else begin
                        n_slot = r_slot + 1'b1;
                    end
                end
            end
            S_DONE: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_slot  <= n_slot;
        end
    end

    a_emit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result loaded while output register busy");

    a_take_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_TAKE) |=> (r_state == S_BRANCH))
        else $error("take did not advance to branch");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_slot <= SLOT_CMD))
        else $error("result slot out of range");

endmodule

// ===== design/tlqe_dp.sv =====
`timescale 1ns / 1ps

module tlqe_dp import tlqe_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    output t_dp_stat                     o_stat,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic                         i_first_point,
    input  logic                         i_final_point,
    tlqe_cfg_if.sink                     i_cfg,
    tlqe_result_if.source                o_res
);

    logic [SW_BITS-1:0]           r_sw;
    logic [COLOR_BITS-1:0]        r_color;
    logic signed [COORD_BITS-1:0] r_prev_x, r_prev_y, r_cur_x, r_cur_y;
    logic                         r_have_prev;
    logic [INDEX_BITS-1:0]        r_vcnt, r_tally;
    logic                         r_fin, r_seg, r_negx, r_negy;
    logic [DIFF_BITS-1:0]         r_ax, r_ay;
    logic [SQ_BITS-2:0]           r_acc;
    logic [RAD_BITS-1:0]          r_rad;
    logic [REM_BITS-1:0]          r_rem;
    logic [ROOT_BITS-1:0]         r_root;
    logic [DVS_BITS-1:0]          r_drem;
    logic [Q_BITS-1:0]            r_dlo, r_q, r_qx;
    logic                         r_out_valid;
    t_kind                        r_kind;
    logic [COORD_BITS-1:0]        r_vx, r_vy;
    logic [COLOR_BITS-1:0]        r_vc;
    logic [INDEX_BITS-1:0]        r_idx;
    logic                         r_last;

    logic                         start;
    logic signed [COORD_BITS:0]   dx, dy, adx, ady;
    logic [SQ_BITS-2:0]           sqx, sqy;
    logic [SQ_BITS-1:0]           sqsum;
    logic [REM_BITS+1:0]          s_rem2, s_trial, s_diff;
    logic                         s_ge;
    logic [DIFF_BITS-1:0]         div_a;
    logic [PROD_BITS-1:0]         prod;
    logic [DVD_BITS-1:0]          dvd;
    logic [DVS_BITS:0]            d_rem2, d_dvs, d_diff;
    logic                         d_ge;
    logic                         zero_len;
    logic signed [COORD_BITS:0]   ox, oy, base_x, base_y, sum_x, sum_y;
    logic [INDEX_BITS-1:0]        tally_new;
    logic                         out_free;

    assign start = i_first_point || !r_have_prev;
    assign dx    = {i_point_x[COORD_BITS-1], i_point_x} - {r_prev_x[COORD_BITS-1], r_prev_x};
    assign dy    = {i_point_y[COORD_BITS-1], i_point_y} - {r_prev_y[COORD_BITS-1], r_prev_y};
    assign adx   = dx[COORD_BITS] ? -dx : dx;
    assign ady   = dy[COORD_BITS] ? -dy : dy;

    assign sqx   = r_ax * r_ax;
    assign sqy   = r_ay * r_ay;
    assign sqsum = {1'b0, r_acc} + {1'b0, sqy};

    // one result bit of the root per step
    assign s_rem2  = {r_rem, r_rad[RAD_BITS-1 -: 2]};
    assign s_trial = {2'b00, r_root, 2'b01};
    assign s_diff  = s_rem2 - s_trial;
    assign s_ge    = (s_rem2 >= s_trial);

    // dividend 2*a*w*8 + l8 over divisor 2*l8, rounding half up
    assign div_a = (i_cmd.op == OP_DIVI_Y) ? r_ay : r_ax;
    assign prod  = div_a * r_sw;
    assign dvd   = {1'b0, prod, 4'b0000} + DVD_BITS'(r_root);

    assign d_rem2 = {r_drem, r_dlo[Q_BITS-1]};
    assign d_dvs  = {1'b0, r_root, 1'b0};
    assign d_diff = d_rem2 - d_dvs;
    assign d_ge   = (d_rem2 >= d_dvs);

    assign zero_len = (r_root == '0);
    always_comb begin
        ox = zero_len ? '0 : (COORD_BITS+1)'(r_qx);
        oy = zero_len ? '0 : (COORD_BITS+1)'(r_q);
        if (r_negx) begin
            ox = -ox;
        end
        if (r_negy) begin
            oy = -oy;
        end
        base_x = i_cmd.slot[0] ? {r_cur_x[COORD_BITS-1], r_cur_x}
                               : {r_prev_x[COORD_BITS-1], r_prev_x};
        base_y = i_cmd.slot[0] ? {r_cur_y[COORD_BITS-1], r_cur_y}
                               : {r_prev_y[COORD_BITS-1], r_prev_y};
        sum_x  = i_cmd.slot[1] ? base_x - oy : base_x + oy;
        sum_y  = i_cmd.slot[1] ? base_y + ox : base_y - ox;
    end

    assign tally_new = r_seg ? r_tally + INDEX_BITS'(6) : r_tally;
    assign out_free  = !r_out_valid || o_res.ready;

    assign o_stat.seg      = r_seg;
    assign o_stat.fin      = r_fin;
    assign o_stat.out_free = out_free;

    assign i_cfg.ready = 1'b1;

    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_kind;
    assign o_res.vert_x      = r_vx;
    assign o_res.vert_y      = r_vy;
    assign o_res.vert_color  = r_vc;
    assign o_res.index_value = r_idx;
    assign o_res.last_result = r_last;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw        <= SW_RESET;
            r_color     <= COLOR_RESET;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_have_prev <= 1'b0;
            r_vcnt      <= '0;
            r_tally     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_STROKE_WIDTH: r_sw    <= i_cfg.data[SW_BITS-1:0];
                    CFG_STROKE_COLOR: r_color <= i_cfg.data[COLOR_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            if ((i_cmd.op == OP_TAKE) && start) begin
                r_tally     <= '0;
                r_have_prev <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_prev_x    <= r_cur_x;
                r_prev_y    <= r_cur_y;
                r_have_prev <= !r_fin;
                r_tally     <= r_fin ? '0 : tally_new;
                if (r_seg) begin
                    r_vcnt <= r_vcnt + INDEX_BITS'(4);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // arithmetic and result payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_TAKE: begin
                r_cur_x <= i_point_x;
                r_cur_y <= i_point_y;
                r_fin   <= i_final_point;
                r_seg   <= !start;
                r_negx  <= dx[COORD_BITS];
                r_negy  <= dy[COORD_BITS];
                r_ax    <= adx[DIFF_BITS-1:0];
                r_ay    <= ady[DIFF_BITS-1:0];
            end
            OP_MULX: begin
                r_acc <= sqx;
            end
            OP_MULY: begin
                r_rad  <= {1'b0, sqsum, 16'd0};
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_SQRT: begin
                r_rad <= {r_rad[RAD_BITS-3:0], 2'b00};
                if (s_ge) begin
                    r_rem  <= s_diff[REM_BITS-1:0];
                    r_root <= {r_root[ROOT_BITS-2:0], 1'b1};
                end else begin
                    r_rem  <= s_rem2[REM_BITS-1:0];
                    r_root <= {r_root[ROOT_BITS-2:0], 1'b0};
                end
            end
            OP_DIVI_X, OP_DIVI_Y: begin
                r_drem <= DVS_BITS'(dvd[DVD_BITS-1:Q_BITS]);
                r_dlo  <= dvd[Q_BITS-1:0];
                r_q    <= '0;
                if (i_cmd.op == OP_DIVI_Y) begin
                    r_qx <= r_q;
                end
            end
            OP_DIV: begin
                r_drem <= d_ge ? d_diff[DVS_BITS-1:0] : d_rem2[DVS_BITS-1:0];
                r_dlo  <= {r_dlo[Q_BITS-2:0], 1'b0};
                r_q    <= {r_q[Q_BITS-2:0], d_ge};
            end
            default: begin
            end
        endcase

        if (i_cmd.emit) begin
            r_last <= (i_cmd.slot == SLOT_CMD) ||
                      ((i_cmd.slot == SLOT_LAST_IDX) && !r_fin);
            if (i_cmd.slot <= SLOT_LAST_VERT) begin
                r_kind <= KIND_VERTEX;
                r_vx   <= sat_coord(sum_x);
                r_vy   <= sat_coord(sum_y);
                r_vc   <= r_color;
                r_idx  <= '0;
            end else begin
                r_kind <= (i_cmd.slot == SLOT_CMD) ? KIND_CMD : KIND_INDEX;
                r_vx   <= '0;
                r_vy   <= '0;
                r_vc   <= '0;
                r_idx  <= (i_cmd.slot == SLOT_CMD) ? tally_new
                                                   : r_vcnt + INDEX_BITS'(tri_ofs(i_cmd.slot));
            end
        end
    end

    a_vcnt_quad_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt[1:0] == 2'b00)
        else $error("vertex counter lost quad alignment");

    a_tally_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tally[0] == 1'b0)
        else $error("index tally is odd");

    a_final_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_fin) |=> (!r_have_prev && (r_tally == '0)))
        else $error("final point left polyline open");

endmodule

// ===== design/thick_line_quad_expander.sv =====
`timescale 1ns / 1ps
// channel  modport  direction  payload
// i_pt     sink     in         point_x, point_y, first_point, final_point
// o_res    source   out        kind, vert_x, vert_y, vert_color, index_value, last_result
// i_cfg    sink     in         index (0 stroke_width, 1 stroke_color), data
//
// a point that closes a segment runs the 29-step root and two 13-step quotient loops,
// then emits ten results (eleven when it also ends the polyline)
// a point without a segment emits only the command, and only when it ends the polyline
// the output register holds a result while the next one is prepared; a stall on o_res
// holds the emit phase until the output register is free
// synchronous active-low reset restores stroke width 256 and color all ones

module thick_line_quad_expander import tlqe_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tlqe_point_if.sink    i_pt,
    tlqe_result_if.source o_res,
    tlqe_cfg_if.sink      i_cfg
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     ready;

    assign i_pt.ready = ready;

    tlqe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pt.valid),
        .i_stat  (stat),
        .o_ready (ready),
        .o_cmd   (cmd)
    );

    tlqe_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_point_x     (i_pt.point_x),
        .i_point_y     (i_pt.point_y),
        .i_first_point (i_pt.first_point),
        .i_final_point (i_pt.final_point),
        .i_cfg         (i_cfg),
        .o_res         (o_res)
    );

endmodule
